// File: rtl/rleu_pkg.sv
// shared constants and types of the run-length image unpacker
package rleu_pkg;

  // video memory address width default
  localparam int AddrBitsDef = 14;

  // register and field widths
  localparam int BaseW    = 14;
  localparam int ImageW   = 15;
  localparam int CfgDataW = 15;
  localparam int CfgIdxW  = 2;
  localparam int ByteW    = 8;
  localparam int LenW     = 7;
  localparam int RemW     = 16;
  localparam int CountW   = 2;

  // reset values of the registers
  localparam logic [BaseW-1:0]  BaseAddrRst   = '0;
  localparam logic [ImageW-1:0] ImageBytesRst = 15'd6144;

  // header byte layout: run flag on top, packet length below
  localparam int RunFlagBit = 7;

  // result byte counts
  localparam logic [CountW-1:0] CountOne = 2'd1;
  localparam logic [CountW-1:0] CountTwo = 2'd2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_IMAGE_BYTES  = 2'd1
  } cfg_idx_e;

  // per-result marks handed from the run sequencer
  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic              run_end;
    logic              image_end;
  } rleu_tag_t;

  // one run job for the run sequencer
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic [LenW-1:0]  len;
    logic             image_end;
  } rleu_job_t;

endpackage

// File: rtl/rleu_ifs.sv
// valid/ready channel interfaces for the code byte input and the result output
interface rleu_in_if;
  logic                       valid;
  logic                       ready;
  logic [rleu_pkg::ByteW-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface rleu_out_if #(
  parameter int AddrW = rleu_pkg::AddrBitsDef
);
  logic                        valid;
  logic                        ready;
  logic [AddrW-1:0]            write_address;
  logic [rleu_pkg::ByteW-1:0]  first_byte;
  logic [rleu_pkg::ByteW-1:0]  second_byte;
  logic [rleu_pkg::CountW-1:0] byte_count;
  logic                        run_end;
  logic                        image_end;

  modport source (output valid, output write_address, output first_byte,
                  output second_byte, output byte_count, output run_end,
                  output image_end, input ready);
  modport sink   (input valid, input write_address, input first_byte,
                  input second_byte, input byte_count, input run_end,
                  input image_end, output ready);
endinterface

// File: rtl/rleu_run_seq.sv
// run sequencer: steps one address adder to emit a run as byte pairs
module rleu_run_seq #(
  parameter int AddrW = rleu_pkg::AddrBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  rleu_pkg::rleu_job_t        job_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic                       slot_free_i,
  output logic                       emit_o,
  output logic [AddrW-1:0]           addr_o,
  output logic [rleu_pkg::ByteW-1:0] value_o,
  output rleu_pkg::rleu_tag_t        tag_o
);

  logic                       busy_q, busy_d;
  logic [rleu_pkg::LenW-1:0]  left_q, left_d;
  logic [AddrW-1:0]           addr_q, addr_d;
  logic [rleu_pkg::ByteW-1:0] value_q, value_d;
  logic                       iend_q, iend_d;
  logic [rleu_pkg::CountW-1:0] cnt;
  logic                       last;

  // pair size and last-pair flag of the current step
  assign cnt  = (left_q >= rleu_pkg::LenW'(2)) ? rleu_pkg::CountTwo : rleu_pkg::CountOne;
  assign last = (left_q <= rleu_pkg::LenW'(2));

  assign emit_o  = busy_q & slot_free_i;
  assign addr_o  = addr_q;
  assign value_o = value_q;
  assign tag_o   = '{byte_count: cnt, run_end: last, image_end: last & iend_q};

  // step control: load a job, then advance one pair per free output slot
  always_comb begin
    busy_d  = busy_q;
    left_d  = left_q;
    addr_d  = addr_q;
    value_d = value_q;
    iend_d  = iend_q;
    if (start_i) begin
      busy_d  = 1'b1;
      left_d  = job_i.len;
      addr_d  = addr_i;
      value_d = job_i.value;
      iend_d  = job_i.image_end;
    end else if (emit_o) begin
      addr_d = addr_q + AddrW'(cnt);
      left_d = left_q - rleu_pkg::LenW'(cnt);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
    end else begin
      busy_q <= busy_d;
      left_q <= left_d;
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    value_q <= value_d;
    iend_q  <= iend_d;
  end

endmodule

// File: rtl/rle_image_unpacker.sv
// run-length image unpacker: decodes a packbits-style byte stream into video memory writes
// a header byte gives no result; a literal byte gives its result in the output register
//   in the cycle after acceptance
// a run value byte of length n gives ceil(n/2) results, one per cycle as the output drains,
//   set by the run sequencer's single address adder; input is held until the last pair leaves
// reset: base_address 0, image_bytes 6144, header phase, image counters rearmed, output empty
module rle_image_unpacker #(
  parameter int ADDR_BITS = rleu_pkg::AddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rleu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rleu_pkg::CfgDataW-1:0] cfg_data_i,
  rleu_in_if.sink                       in_i,
  rleu_out_if.source                    out_o
);

  localparam int AddrW = ADDR_BITS;
  localparam int LenW  = rleu_pkg::LenW;
  localparam int RemW  = rleu_pkg::RemW;
  localparam int ByteW = rleu_pkg::ByteW;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_RUNVAL,
    ST_LITERAL,
    ST_EMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [rleu_pkg::BaseW-1:0]  base_q, base_d;
  logic [rleu_pkg::ImageW-1:0] image_q, image_d;
  logic [LenW-1:0]             len_q, len_d;
  logic [LenW-1:0]             left_q, left_d;
  logic signed [RemW-1:0]      rem_q, rem_d;
  logic [AddrW-1:0]            naddr_q, naddr_d;

  logic                        out_valid_q, out_valid_d;
  logic [AddrW-1:0]            out_addr_q, out_addr_d;
  logic [ByteW-1:0]            out_first_q, out_first_d;
  logic [ByteW-1:0]            out_second_q, out_second_d;
  rleu_pkg::rleu_tag_t         out_tag_q, out_tag_d;

  logic                        in_fire;
  logic                        slot_free;
  logic [ByteW-1:0]            code;
  logic signed [RemW-1:0]      rem_after;
  logic                        img_done;
  logic                        run_start;
  rleu_pkg::rleu_job_t         run_job;
  logic                        run_emit;
  logic [AddrW-1:0]            run_addr;
  logic [ByteW-1:0]            run_value;
  rleu_pkg::rleu_tag_t         run_tag;

  // handshake
  assign code      = in_i.code_byte;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q != ST_EMIT) && slot_free;
  assign in_fire   = in_i.valid && in_i.ready;

  // image byte count after the pending packet
  assign rem_after = rem_q - $signed({{(RemW-LenW){1'b0}}, len_q});
  assign img_done  = (rem_after <= 0);

  assign run_job = '{value: code, len: len_q, image_end: img_done};

  // packet decode, image tracking and configuration
  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    image_d      = image_q;
    len_d        = len_q;
    left_d       = left_q;
    rem_d        = rem_q;
    naddr_d      = naddr_q;
    run_start    = 1'b0;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_addr_d   = out_addr_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    out_tag_d    = out_tag_q;

    if (in_fire) begin
      case (state_q)
        ST_RUNVAL: begin
          len_d   = '0;
          state_d = ST_HEADER;
          if (len_q != '0) begin
            run_start = 1'b1;
            state_d   = ST_EMIT;
            if (img_done) begin
              rem_d   = $signed({1'b0, image_q});
              naddr_d = AddrW'(base_q);
            end else begin
              rem_d   = rem_after;
              naddr_d = naddr_q + AddrW'(len_q);
            end
          end
        end
        ST_LITERAL: begin
          out_valid_d  = 1'b1;
          out_addr_d   = naddr_q;
          out_first_d  = code;
          out_second_d = '0;
          out_tag_d    = '{byte_count: rleu_pkg::CountOne, run_end: 1'b1, image_end: 1'b0};
          naddr_d      = naddr_q + AddrW'(1);
          left_d       = left_q - LenW'(1);
          if (left_q == LenW'(1)) begin
            state_d = ST_HEADER;
            len_d   = '0;
            out_tag_d.image_end = img_done;
            if (img_done) begin
              rem_d   = $signed({1'b0, image_q});
              naddr_d = AddrW'(base_q);
            end else begin
              rem_d = rem_after;
            end
          end
        end
        default: begin
          // header byte: run flag or literal count
          len_d = code[LenW-1:0];
          if (code[rleu_pkg::RunFlagBit]) begin
            state_d = ST_RUNVAL;
          end else begin
            left_d  = code[LenW-1:0];
            state_d = (code == '0) ? ST_HEADER : ST_LITERAL;
          end
        end
      endcase
    end

    // run pairs from the sequencer
    if (run_emit) begin
      out_valid_d  = 1'b1;
      out_addr_d   = run_addr;
      out_first_d  = run_value;
      out_second_d = (run_tag.byte_count == rleu_pkg::CountTwo) ? run_value : '0;
      out_tag_d    = run_tag;
      if (run_tag.run_end) begin
        state_d = ST_HEADER;
      end
    end

    // base address and image size writes rearm the image
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rleu_pkg::CFG_BASE_ADDRESS: begin
          base_d  = cfg_data_i[rleu_pkg::BaseW-1:0];
          rem_d   = $signed({1'b0, image_q});
          naddr_d = AddrW'(cfg_data_i[rleu_pkg::BaseW-1:0]);
        end
        rleu_pkg::CFG_IMAGE_BYTES: begin
          image_d = cfg_data_i[rleu_pkg::ImageW-1:0];
          rem_d   = $signed({1'b0, cfg_data_i[rleu_pkg::ImageW-1:0]});
          naddr_d = AddrW'(base_q);
        end
        default: begin
        end
      endcase
    end
  end

  // run pair sequencer
  rleu_run_seq #(
    .AddrW (AddrW)
  ) u_run_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (run_start),
    .job_i       (run_job),
    .addr_i      (naddr_q),
    .slot_free_i (slot_free),
    .emit_o      (run_emit),
    .addr_o      (run_addr),
    .value_o     (run_value),
    .tag_o       (run_tag)
  );

  // control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HEADER;
      base_q      <= rleu_pkg::BaseAddrRst;
      image_q     <= rleu_pkg::ImageBytesRst;
      len_q       <= '0;
      left_q      <= '0;
      rem_q       <= $signed({1'b0, rleu_pkg::ImageBytesRst});
      naddr_q     <= AddrW'(rleu_pkg::BaseAddrRst);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      image_q     <= image_d;
      len_q       <= len_d;
      left_q      <= left_d;
      rem_q       <= rem_d;
      naddr_q     <= naddr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_addr_q   <= out_addr_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
    out_tag_q    <= out_tag_d;
  end

  // output channel
  assign out_o.valid         = out_valid_q;
  assign out_o.write_address = out_addr_q;
  assign out_o.first_byte    = out_first_q;
  assign out_o.second_byte   = out_second_q;
  assign out_o.byte_count    = out_tag_q.byte_count;
  assign out_o.run_end       = out_tag_q.run_end;
  assign out_o.image_end     = out_tag_q.image_end;

endmodule

// File: tb/tb.sv
// self-checking testbench of the run-length image unpacker
`timescale 1ns / 100ps

module tb;
  import rleu_pkg::*;

  localparam int AddrW = AddrBitsDef;
  localparam int StimItems = 310;
  localparam int SettleCycles = 8;
  localparam int WatchdogLimit = 2000;
  localparam logic [ByteW-1:0] RunFlag = 8'h80;
  // register indexes beyond the list, which the block ignores
  localparam logic [CfgIdxW-1:0] IdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] IdxSpareB = 2'd3;

  typedef enum logic [1:0] {
    AWAIT_HEADER,
    AWAIT_VALUE,
    IN_LITERAL
  } unpack_phase_e;

  typedef struct packed {
    logic [AddrW-1:0]  write_address;
    logic [ByteW-1:0]  first_byte;
    logic [ByteW-1:0]  second_byte;
    logic [CountW-1:0] byte_count;
    logic              run_end;
    logic              image_end;
  } vram_write_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  rleu_in_if                   code_ch ();
  rleu_out_if #(.AddrW(AddrW)) vram_ch ();

  rle_image_unpacker #(.ADDR_BITS(AddrW)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (code_ch),
    .out_o      (vram_ch)
  );

  // stream bytes waiting to be sent and video memory writes still owed
  logic [ByteW-1:0] code_q[$];
  vram_write_t      write_q[$];
  int               n_errors = 0;
  int               n_sent = 0;

  // decoder state kept on the testbench side
  unpack_phase_e    dec_phase;
  logic [LenW-1:0]  lit_left;
  logic [LenW-1:0]  pkt_len;
  int               owed;
  logic [AddrW-1:0] next_addr;
  logic [BaseW-1:0] cfg_base;
  logic [ImageW-1:0] cfg_image;

  logic steady = 1'b0;
  int   pace_left = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // restart the image at the configured base and size
  function automatic void rearm_image();
    owed = int'(cfg_image);
    next_addr = cfg_base;
  endfunction

  // charge a finished packet to the image, true when the image completes
  function automatic logic close_packet(input logic [LenW-1:0] len);
    owed = owed - int'(len);
    if (owed <= 0) begin
      rearm_image();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_BASE_ADDRESS: begin
        cfg_base = data[BaseW-1:0];
        rearm_image();
      end
      CFG_IMAGE_BYTES: begin
        cfg_image = data[ImageW-1:0];
        rearm_image();
      end
      default: ;
    endcase
  endfunction

  // work out the memory writes one code byte causes
  function automatic void decode_byte(input logic [ByteW-1:0] b);
    int               len;
    int               done;
    logic [AddrW-1:0] addr;
    logic             iend;
    vram_write_t      w;
    case (dec_phase)
      AWAIT_VALUE: begin
        len = int'(pkt_len);
        addr = next_addr;
        dec_phase = AWAIT_HEADER;
        pkt_len = '0;
        if (len != 0) begin
          next_addr = AddrW'(addr + len);
          iend = close_packet(len[LenW-1:0]);
          done = 0;
          // the run goes out as pairs, a single byte last when odd
          while (done < len) begin
            w.byte_count = (len - done >= 2) ? CountTwo : CountOne;
            w.write_address = AddrW'(addr + done);
            w.first_byte = b;
            w.second_byte = (w.byte_count == CountTwo) ? b : '0;
            done = done + int'(w.byte_count);
            w.run_end = (done == len);
            w.image_end = w.run_end & iend;
            write_q.push_back(w);
          end
        end
      end
      IN_LITERAL: begin
        w.write_address = next_addr;
        next_addr = next_addr + 1'b1;
        lit_left = lit_left - 1'b1;
        w.image_end = 1'b0;
        if (lit_left == '0) begin
          dec_phase = AWAIT_HEADER;
          w.image_end = close_packet(pkt_len);
          pkt_len = '0;
        end
        w.first_byte = b;
        w.second_byte = '0;
        w.byte_count = CountOne;
        w.run_end = 1'b1;
        write_q.push_back(w);
      end
      default: begin
        // header: run flag selects run or literal packet
        pkt_len = b[LenW-1:0];
        if (b[RunFlagBit]) begin
          dec_phase = AWAIT_VALUE;
        end else begin
          lit_left = b[LenW-1:0];
          dec_phase = (b == '0) ? AWAIT_HEADER : IN_LITERAL;
        end
      end
    endcase
  endfunction

  // idle length, mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // switch between paced and back-to-back stretches
  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      steady <= ($urandom_range(0, 3) == 0);
      pace_left = $urandom_range(20, 120);
    end else begin
      pace_left--;
    end
  end

  // code byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      code_ch.valid <= 1'b0;
    end else if (!code_ch.valid || code_ch.ready) begin
      if (hold_left > 0) begin
        hold_left--;
        code_ch.valid <= 1'b0;
      end else if (code_q.size() > 0) begin
        code_ch.code_byte <= code_q.pop_front();
        code_ch.valid <= 1'b1;
        hold_left = pick_gap();
      end else begin
        code_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      vram_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      vram_ch.ready <= 1'b0;
    end else begin
      vram_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // predict on accepted code bytes, check accepted writes
  always @(posedge clk_i) begin
    vram_write_t exp_w;
    if (rst_ni) begin
      if (cfg_we) apply_reg(cfg_idx, cfg_data);
      if (code_ch.valid && code_ch.ready) decode_byte(code_ch.code_byte);
      if (vram_ch.valid && vram_ch.ready) begin
        if (write_q.size() == 0) begin
          $error("unexpected write at %0h byte %0h", vram_ch.write_address,
                 vram_ch.first_byte);
          n_errors++;
        end else begin
          exp_w = write_q.pop_front();
          if (vram_ch.write_address !== exp_w.write_address) begin
            $error("write_address expected %0h got %0h", exp_w.write_address,
                   vram_ch.write_address);
            n_errors++;
          end
          if (vram_ch.first_byte !== exp_w.first_byte) begin
            $error("first_byte expected %0h got %0h", exp_w.first_byte,
                   vram_ch.first_byte);
            n_errors++;
          end
          if (vram_ch.second_byte !== exp_w.second_byte) begin
            $error("second_byte expected %0h got %0h", exp_w.second_byte,
                   vram_ch.second_byte);
            n_errors++;
          end
          if (vram_ch.byte_count !== exp_w.byte_count) begin
            $error("byte_count expected %0d got %0d", exp_w.byte_count,
                   vram_ch.byte_count);
            n_errors++;
          end
          if (vram_ch.run_end !== exp_w.run_end) begin
            $error("run_end expected %0b got %0b", exp_w.run_end, vram_ch.run_end);
            n_errors++;
          end
          if (vram_ch.image_end !== exp_w.image_end) begin
            $error("image_end expected %0b got %0b", exp_w.image_end,
                   vram_ch.image_end);
            n_errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((code_ch.valid && code_ch.ready) || (vram_ch.valid && vram_ch.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send(input logic [ByteW-1:0] b);
    code_q.push_back(b);
    n_sent++;
  endtask

  // wait until every byte is taken and every write has come out
  task automatic settle();
    do @(negedge clk_i);
    while (code_q.size() != 0 || code_ch.valid || write_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // well-formed packets with random content, some stray bytes between
  task automatic send_packets(input int n_bytes);
    int r;
    int len;
    int stop;
    stop = n_sent + n_bytes;
    while (n_sent < stop) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      if (r < 45) begin
        if (len < 5) len = 0;
        else if (len < 85) len = $urandom_range(1, 12);
        else if (len < 95) len = $urandom_range(13, 40);
        else len = $urandom_range(41, 127);
        send(RunFlag | len[ByteW-1:0]);
        send(ByteW'($urandom_range(0, 255)));
      end else if (r < 90) begin
        if (len < 5) len = 0;
        else if (len < 90) len = $urandom_range(1, 8);
        else len = $urandom_range(9, 24);
        send(len[ByteW-1:0]);
        repeat (len) send(ByteW'($urandom_range(0, 255)));
      end else begin
        send(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int r;
    logic [CfgDataW-1:0] val;
    rst_ni = 1'b0;
    cfg_base = BaseAddrRst;
    cfg_image = ImageBytesRst;
    dec_phase = AWAIT_HEADER;
    lit_left = '0;
    pkt_len = '0;
    rearm_image();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: literal extremes, longest run, single, empty packets
    send(8'h03);
    send(8'h00);
    send(8'hff);
    send(8'ha5);
    send(RunFlag | 8'd127);
    send(8'h5a);
    send(RunFlag | 8'd1);
    send(8'h00);
    send(RunFlag);
    send(8'h77);
    send(8'h00);
    send(RunFlag | 8'd2);
    send(8'hff);
    settle();

    // top base address: pair wraps, images end on run and on literal
    write_reg(CFG_BASE_ADDRESS, 15'd16383);
    write_reg(CFG_IMAGE_BYTES, 15'd3);
    send(RunFlag | 8'd2);
    send(8'h11);
    send(8'h02);
    send(8'haa);
    send(8'h55);
    send(RunFlag | 8'd5);
    send(8'h33);
    settle();

    // zero image size, ignored indexes, register write inside a literal
    write_reg(CFG_BASE_ADDRESS, 15'd0);
    write_reg(CFG_IMAGE_BYTES, 15'd0);
    write_reg(IdxSpareA, CfgDataW'($urandom_range(0, 32767)));
    write_reg(IdxSpareB, CfgDataW'($urandom_range(0, 32767)));
    send(RunFlag | 8'd1);
    send(8'h42);
    send(8'h02);
    settle();
    write_reg(CFG_BASE_ADDRESS, 15'h1234);
    send(8'hc3);
    send(8'h3c);
    settle();

    // random phases with fresh settings between them
    while (n_sent < StimItems) begin
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 20) val = 15'd0;
        else if (r < 40) val = CfgDataW'(16383 - $urandom_range(0, 3));
        else val = CfgDataW'($urandom_range(0, 16383));
        write_reg(CFG_BASE_ADDRESS, val);
      end
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 40) val = CfgDataW'($urandom_range(1, 40));
        else if (r < 60) val = CfgDataW'($urandom_range(41, 300));
        else if (r < 75) val = 15'd1;
        else if (r < 85) val = 15'd16384;
        else val = CfgDataW'($urandom_range(1, 16384));
        write_reg(CFG_IMAGE_BYTES, val);
      end
      send_packets($urandom_range(30, 60));
      settle();
    end

    if (write_q.size() != 0) begin
      $error("%0d expected writes never arrived", write_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: rle_image_unpacker.f
rtl/rleu_pkg.sv
rtl/rleu_ifs.sv
rtl/rleu_run_seq.sv
rtl/rle_image_unpacker.sv
tb/tb.sv
